// ===== rtl/core/trn_pkg.sv =====
// Shared types and constants for the telnet receive negotiator.
`timescale 1ns / 1ps
`default_nettype none

package trn_pkg;

  // Telnet command bytes
  localparam logic [7:0] CMD_EOR  = 8'd239;
  localparam logic [7:0] CMD_SE   = 8'd240;
  localparam logic [7:0] CMD_GA   = 8'd249;
  localparam logic [7:0] CMD_SB   = 8'd250;
  localparam logic [7:0] CMD_WILL = 8'd251;
  localparam logic [7:0] CMD_WONT = 8'd252;
  localparam logic [7:0] CMD_DO   = 8'd253;
  localparam logic [7:0] CMD_DONT = 8'd254;
  localparam logic [7:0] CMD_IAC  = 8'd255;

  // Option codes
  localparam logic [7:0] OPT_ECHO  = 8'd1;
  localparam logic [7:0] OPT_TTYPE = 8'd24;
  localparam logic [7:0] OPT_EOR   = 8'd25;
  localparam logic [7:0] OPT_NAWS  = 8'd31;
  localparam logic [7:0] OPT_COMP2 = 8'd86;

  // Result channels
  localparam logic [1:0] CH_NONE   = 2'd0;
  localparam logic [1:0] CH_USER   = 2'd1;
  localparam logic [1:0] CH_SOCKET = 2'd2;
  localparam logic [1:0] CH_EVENT  = 2'd3;

  // Event codes
  localparam logic [1:0] EV_GO_AHEAD  = 2'd0;
  localparam logic [1:0] EV_TTYPE     = 2'd1;
  localparam logic [1:0] EV_COMPRESS  = 2'd2;
  localparam logic [1:0] EV_SB_TOO_LONG = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_COLS    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TERM_LINES   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_LINE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MCCP_ENABLED = 4'd3;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0] TERM_COLS_RST    = 16'd80;
  localparam logic [15:0] TERM_LINES_RST   = 16'd25;
  localparam logic        STATUS_LINE_RST  = 1'b0;
  localparam logic        MCCP_ENABLED_RST = 1'b1;

  localparam int SUBNEG_LIMIT_DEF = 64;

  typedef struct packed {
    logic [15:0] term_cols;
    logic [15:0] term_lines;
    logic        status_line;
    logic        mccp_enabled;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       mccp_window;
  } in_item_t;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] out_byte;
    logic [1:0] event_code;
    logic       last;
    logic [1:0] echo_mode;
    logic       naws_on;
    logic       go_ahead_seen;
  } out_item_t;

  typedef enum logic [2:0] {
    JOB_NONE,
    JOB_DATA,
    JOB_EVENT,
    JOB_REPLY,
    JOB_NAWS
  } job_kind_t;

  // Everything one received byte asks the emitter to send
  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] arg;        // data byte, event argument or reply verb
    logic [1:0] ev;
    logic [7:0] opt;
    logic [7:0] cols_hi;
    logic [7:0] cols_lo;
    logic [7:0] rows_hi;
    logic [7:0] rows_lo;
    logic [1:0] echo_mode;
    logic       naws_on;
    logic       go_ahead_seen;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/trn_parser.sv =====
// Telnet byte parser: protocol state and per-byte job decode.
`timescale 1ns / 1ps
`default_nettype none

module trn_parser import trn_pkg::*; #(
  parameter int SUBNEG_LIMIT = SUBNEG_LIMIT_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire in_item_t in_item,
  input  wire cfg_t     cfg,
  output job_t          job
);

  localparam int CNT_W = $clog2(SUBNEG_LIMIT + 2);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(SUBNEG_LIMIT);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);

  localparam logic [1:0] VERB_WILL = 2'd0;
  localparam logic [1:0] VERB_WONT = 2'd1;
  localparam logic [1:0] VERB_DO   = 2'd2;

  localparam logic [1:0] ECHO_SERVER = 2'd1;
  localparam logic [1:0] ECHO_LOCAL  = 2'd2;

  typedef enum logic [2:0] {
    PH_DATA,
    PH_IAC,
    PH_VERB,
    PH_SB,
    PH_SBIAC
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [1:0]       verb_r, verb_nxt;
  logic [CNT_W-1:0] sub_count_r, sub_count_nxt;
  logic [7:0]       sub_option_r, sub_option_nxt;
  logic [7:0]       sub_second_r, sub_second_nxt;
  logic [1:0]       echo_r, echo_nxt;
  logic             naws_r, naws_nxt;
  logic             mccp_allowed_r, mccp_allowed_nxt;
  logic             ga_r, ga_nxt;
  logic [1:0]       ttype_idx_r, ttype_idx_nxt;
  logic             ttype_rep_r, ttype_rep_nxt;

  logic [7:0]  b;
  logic        do_store;
  logic        do_finish;
  logic [7:0]  refuse;
  logic [7:0]  accept_will;
  logic [7:0]  reply;
  logic [16:0] row_sub;
  logic [15:0] rows;

  assign b = in_item.rx_byte;

  always_comb begin
    row_sub = {16'd0, cfg.status_line} + 17'd1;
    rows    = ({1'b0, cfg.term_lines} > row_sub) ?
              16'(({1'b0, cfg.term_lines} - row_sub)) : 16'd0;
    refuse  = verb_r[1] ? CMD_WONT : CMD_DONT;
    unique case (verb_r)
      VERB_WILL: accept_will = CMD_DO;
      VERB_WONT: accept_will = CMD_DONT;
      default:   accept_will = CMD_WONT;
    endcase
  end

  always_comb begin
    phase_nxt        = phase_r;
    verb_nxt         = verb_r;
    sub_count_nxt    = sub_count_r;
    sub_option_nxt   = sub_option_r;
    sub_second_nxt   = sub_second_r;
    echo_nxt         = echo_r;
    naws_nxt         = naws_r;
    mccp_allowed_nxt = mccp_allowed_r;
    ga_nxt           = ga_r;
    ttype_idx_nxt    = ttype_idx_r;
    ttype_rep_nxt    = ttype_rep_r;
    do_store         = 1'b0;
    do_finish        = 1'b0;
    reply            = refuse;

    job         = '0;
    job.kind    = JOB_NONE;
    job.opt     = b;
    job.cols_hi = cfg.term_cols[15:8];
    job.cols_lo = cfg.term_cols[7:0];
    job.rows_hi = rows[15:8];
    job.rows_lo = rows[7:0];

    unique case (phase_r)
      PH_IAC: begin
        phase_nxt = PH_DATA;
        if (b >= CMD_WILL && b <= CMD_DONT) begin
          verb_nxt  = 2'(b - CMD_WILL);
          phase_nxt = PH_VERB;
        end else if (b == CMD_SB) begin
          sub_count_nxt = '0;
          phase_nxt     = PH_SB;
        end else if (b == CMD_GA || b == CMD_EOR) begin
          ga_nxt    = 1'b1;
          job.kind  = JOB_EVENT;
          job.ev    = EV_GO_AHEAD;
        end else if (b == CMD_IAC) begin
          job.kind = JOB_DATA;
          job.arg  = CMD_IAC;
        end
      end
      PH_VERB: begin
        phase_nxt = PH_DATA;
        if (b == OPT_ECHO || b == OPT_EOR || (b == OPT_COMP2 && cfg.mccp_enabled)) begin
          reply = accept_will;
          if (b == OPT_ECHO) begin
            if (verb_r == VERB_WILL) echo_nxt = ECHO_SERVER;
            else if (verb_r == VERB_WONT) echo_nxt = ECHO_LOCAL;
          end else if (b == OPT_COMP2) begin
            if (verb_r == VERB_WILL) mccp_allowed_nxt = in_item.mccp_window;
            else if (verb_r == VERB_WONT) mccp_allowed_nxt = 1'b0;
          end
        end else if (b == OPT_TTYPE) begin
          if (verb_r == VERB_DO) reply = CMD_WILL;
        end else if (b == OPT_NAWS) begin
          if (verb_r == VERB_DO) begin
            reply    = CMD_WILL;
            naws_nxt = (cfg.term_lines > 16'd1) && (cfg.term_cols != 16'd0);
          end else begin
            reply    = accept_will;
            naws_nxt = 1'b0;
          end
        end
        job.kind = (b == OPT_NAWS) ? JOB_NAWS : JOB_REPLY;
        job.arg  = reply;
      end
      PH_SB: begin
        if (b == CMD_IAC) phase_nxt = PH_SBIAC;
        else do_store = 1'b1;
      end
      PH_SBIAC: begin
        if (b == CMD_SE) begin
          do_finish = 1'b1;
        end else begin
          phase_nxt = PH_SB;
          do_store  = 1'b1;
        end
      end
      default: begin
        phase_nxt = (b == CMD_IAC) ? PH_IAC : PH_DATA;
        if (b != CMD_IAC) begin
          job.kind = JOB_DATA;
          job.arg  = b;
        end
      end
    endcase

    if (do_store) begin
      if (sub_count_r > CNT_LIMIT) begin
        // overflow: drop what was gathered and resync on data
        job.kind      = JOB_EVENT;
        job.ev        = EV_SB_TOO_LONG;
        sub_count_nxt = '0;
        phase_nxt     = PH_DATA;
      end else begin
        if (sub_count_r == '0) sub_option_nxt = b;
        else if (sub_count_r == CNT_ONE) sub_second_nxt = b;
        sub_count_nxt = sub_count_r + CNT_ONE;
      end
    end

    if (do_finish) begin
      if (sub_count_r >= CNT_TWO && sub_option_r == OPT_TTYPE && sub_second_r == 8'd1) begin
        job.kind = JOB_EVENT;
        job.ev   = EV_TTYPE;
        job.arg  = {6'd0, ttype_idx_r};
        // index sequence 0,1,2,3,3,0,...
        if (ttype_idx_r != 2'd3) begin
          ttype_idx_nxt = ttype_idx_r + 2'd1;
        end else if (!ttype_rep_r) begin
          ttype_rep_nxt = 1'b1;
        end else begin
          ttype_rep_nxt = 1'b0;
          ttype_idx_nxt = 2'd0;
        end
      end else if (sub_count_r >= CNT_ONE && sub_option_r == OPT_COMP2 &&
                   cfg.mccp_enabled && mccp_allowed_r) begin
        job.kind = JOB_EVENT;
        job.ev   = EV_COMPRESS;
      end
      sub_count_nxt = '0;
      phase_nxt     = PH_DATA;
    end

    job.echo_mode     = echo_nxt;
    job.naws_on       = naws_nxt;
    job.go_ahead_seen = ga_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_DATA;
      verb_r         <= '0;
      sub_count_r    <= '0;
      sub_option_r   <= '0;
      sub_second_r   <= '0;
      echo_r         <= '0;
      naws_r         <= 1'b0;
      mccp_allowed_r <= 1'b0;
      ga_r           <= 1'b0;
      ttype_idx_r    <= '0;
      ttype_rep_r    <= 1'b0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      verb_r         <= verb_nxt;
      sub_count_r    <= sub_count_nxt;
      sub_option_r   <= sub_option_nxt;
      sub_second_r   <= sub_second_nxt;
      echo_r         <= echo_nxt;
      naws_r         <= naws_nxt;
      mccp_allowed_r <= mccp_allowed_nxt;
      ga_r           <= ga_nxt;
      ttype_idx_r    <= ttype_idx_nxt;
      ttype_rep_r    <= ttype_rep_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/trn_emitter.sv =====
// Result emitter: holds one job and sends its results one per cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none

module trn_emitter import trn_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  job_load,
  input  wire job_t  job_in,
  output logic       job_free,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_item
);

  // Slot layout of a negotiation reply; size slots come in pairs,
  // the even one only sent when the byte is 255.
  localparam logic [3:0] SL_IAC0    = 4'd0;
  localparam logic [3:0] SL_REPLY   = 4'd1;
  localparam logic [3:0] SL_OPT     = 4'd2;
  localparam logic [3:0] SL_IAC1    = 4'd3;
  localparam logic [3:0] SL_SB      = 4'd4;
  localparam logic [3:0] SL_NAWS    = 4'd5;
  localparam logic [3:0] SL_SIZE_LO = 4'd6;
  localparam logic [3:0] SL_SIZE_HI = 4'd13;
  localparam logic [3:0] SL_IAC2    = 4'd14;
  localparam logic [3:0] SL_SE      = 4'd15;

  job_t       job_r;
  logic       job_v_r;
  logic [3:0] slot_r;
  logic       out_v_r;
  out_item_t  out_r;

  logic [15:0] mask;
  logic [3:0]  last_slot;
  logic [3:0]  slot_inc;
  logic [3:0]  slot_nxt;
  logic        is_last;
  logic        out_load;
  logic        emit;
  logic [1:0]  size_sel;
  logic [7:0]  size_byte;
  out_item_t   res;

  always_comb begin
    mask      = 16'h0001;
    last_slot = SL_IAC0;
    case (job_r.kind)
      JOB_REPLY: begin
        mask      = 16'h0007;
        last_slot = SL_OPT;
      end
      JOB_NAWS: begin
        mask      = 16'hAABF;
        mask[6]   = (job_r.cols_hi == CMD_IAC);
        mask[8]   = (job_r.cols_lo == CMD_IAC);
        mask[10]  = (job_r.rows_hi == CMD_IAC);
        mask[12]  = (job_r.rows_lo == CMD_IAC);
        mask[14]  = 1'b1;
        mask[15]  = 1'b1;
        last_slot = SL_SE;
      end
      default: ;
    endcase
    slot_inc = slot_r + 4'd1;
    slot_nxt = mask[slot_inc] ? slot_inc : slot_r + 4'd2;
    is_last  = (slot_r == last_slot);
  end

  always_comb begin
    size_sel = 2'((slot_r - SL_SIZE_LO) >> 1);
    case (size_sel)
      2'd0:    size_byte = job_r.cols_hi;
      2'd1:    size_byte = job_r.cols_lo;
      2'd2:    size_byte = job_r.rows_hi;
      default: size_byte = job_r.rows_lo;
    endcase

    res               = '0;
    res.last          = is_last;
    res.echo_mode     = job_r.echo_mode;
    res.naws_on       = job_r.naws_on;
    res.go_ahead_seen = job_r.go_ahead_seen;
    case (job_r.kind)
      JOB_DATA: begin
        res.channel  = CH_USER;
        res.out_byte = job_r.arg;
      end
      JOB_EVENT: begin
        res.channel    = CH_EVENT;
        res.out_byte   = job_r.arg;
        res.event_code = job_r.ev;
      end
      JOB_REPLY, JOB_NAWS: begin
        res.channel = CH_SOCKET;
        if (slot_r == SL_IAC0 || slot_r == SL_IAC1 || slot_r == SL_IAC2) begin
          res.out_byte = CMD_IAC;
        end else if (slot_r == SL_REPLY) begin
          res.out_byte = job_r.arg;
        end else if (slot_r == SL_OPT) begin
          res.out_byte = job_r.opt;
        end else if (slot_r == SL_SB) begin
          res.out_byte = CMD_SB;
        end else if (slot_r == SL_NAWS) begin
          res.out_byte = OPT_NAWS;
        end else if (slot_r >= SL_SIZE_LO && slot_r <= SL_SIZE_HI) begin
          res.out_byte = size_byte;
        end else begin
          res.out_byte = CMD_SE;
        end
      end
      default: res.channel = CH_NONE;
    endcase
  end

  assign out_load  = !out_v_r || !out_stall;
  assign emit      = job_v_r && out_load;
  assign job_free  = !job_v_r || (emit && is_last);
  assign out_valid = out_v_r;
  assign out_item  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      slot_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (job_load) begin
        job_v_r <= 1'b1;
        slot_r  <= '0;
      end else if (emit && is_last) begin
        job_v_r <= 1'b0;
        slot_r  <= '0;
      end else if (emit) begin
        slot_r <= slot_nxt;
      end
      if (out_load) out_v_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (job_load) job_r <= job_in;
    if (emit) out_r <= res;
  end

endmodule

`default_nettype wire

// ===== rtl/core/telnet_receive_negotiator_core.sv =====
// Top level of the telnet receive negotiator: config registers, parser, emitter.
//
//  port group | dir | handshake               | payload
//  -----------+-----+-------------------------+-----------------------------
//  in_        | in  | in_valid / in_stall     | in_item  (rx_byte, window)
//  out_       | out | out_valid / out_stall   | out_item (one result)
//  cfg_       | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Each item yields its results in turn: one for data bytes, events and
// ignored bytes, three for an option reply, 16 at most with a size report.
// The emitter sends one result per unstalled cycle from a one-item job register;
// the next item is taken in the cycle the current item's last result loads.
// Reset is synchronous; config returns to its defaults and the parser to data.
// out_stall holds the output register; in_stall rises only while results remain.
`timescale 1ns / 1ps
`default_nettype none

module telnet_receive_negotiator_core import trn_pkg::*; #(
  parameter int SUBNEG_LIMIT = SUBNEG_LIMIT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  job_t job;
  logic job_free;
  logic accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = !job_free;
  assign accept    = in_valid && job_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.term_cols    <= TERM_COLS_RST;
      cfg_r.term_lines   <= TERM_LINES_RST;
      cfg_r.status_line  <= STATUS_LINE_RST;
      cfg_r.mccp_enabled <= MCCP_ENABLED_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TERM_COLS:    cfg_r.term_cols    <= cfg_data;
        CFG_TERM_LINES:   cfg_r.term_lines   <= cfg_data;
        CFG_STATUS_LINE:  cfg_r.status_line  <= cfg_data[0];
        CFG_MCCP_ENABLED: cfg_r.mccp_enabled <= cfg_data[0];
        default: ;
      endcase
    end
  end

  trn_parser #(
    .SUBNEG_LIMIT(SUBNEG_LIMIT)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_item (in_item),
    .cfg     (cfg_r),
    .job     (job)
  );

  trn_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_load  (accept),
    .job_in    (job),
    .job_free  (job_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the telnet receive negotiator core.
`timescale 1ns / 1ps

module testbench;
  import trn_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 8;
  localparam int MAX_REPORTS = 200;
  localparam int SCRIPT_LEN = 25;
  localparam int N_KINDS = 10;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] ECHO_SERVER = 2'd1;
  localparam logic [1:0] ECHO_LOCAL = 2'd2;
  localparam logic [7:0] TTYPE_SEND = 8'd1;

  typedef enum logic [2:0] {PH_DATA, PH_IAC, PH_VERB, PH_SB, PH_SBIAC} parse_phase_t;
  typedef enum logic [1:0] {VB_WILL, VB_WONT, VB_DO, VB_DONT} verb_t;
  typedef enum int {
    SEQ_DATA, SEQ_ESCAPE, SEQ_NEGOTIATE, SEQ_MARK, SEQ_SB_TTYPE,
    SEQ_SB_COMPRESS, SEQ_SB_MIXED, SEQ_SB_LONG, SEQ_OTHER_CMD, SEQ_NOISE
  } seq_kind_t;

  // One directed item; typed rows carry their single expected result
  typedef struct packed {
    logic [7:0] rx;
    logic       window;
    logic       typed;
    logic [1:0] channel;
    logic [7:0] out_byte;
    logic [1:0] event_code;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  in_item_t in_item = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_stall, out_valid, cfg_ready;
  out_item_t out_item;

  telnet_receive_negotiator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the block: parser state, option flags and registers
  parse_phase_t parse_q;
  verb_t verb_q;
  int sb_len;
  logic [7:0] sb_option, sb_second;
  logic [1:0] echo_q;
  logic naws_q, compress_ok, ga_q;
  logic [1:0] ttype_idx;
  logic ttype_wrap;
  logic [15:0] cols_cfg, lines_cfg;
  logic status_cfg, mccp_cfg;

  out_item_t pending[$];
  out_item_t expected_results[$];
  logic [7:0] burst[$];
  bit overflow_done = 1'b0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  script_row_t script_rows [SCRIPT_LEN] = '{
    '{8'h00,     1'b0, 1'b1, CH_USER,  8'h00,   EV_NONE},
    '{8'hFE,     1'b1, 1'b1, CH_USER,  8'hFE,   EV_NONE},
    '{8'h7F,     1'b0, 1'b1, CH_USER,  8'h7F,   EV_NONE},
    '{CMD_IAC,   1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_IAC,   1'b1, 1'b1, CH_USER,  CMD_IAC, EV_NONE},
    '{CMD_IAC,   1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_GA,    1'b1, 1'b1, CH_EVENT, 8'h00,   EV_GO_AHEAD},
    '{CMD_IAC,   1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_DO,    1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{OPT_NAWS,  1'b0, 1'b0, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_IAC,   1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_WILL,  1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{OPT_ECHO,  1'b0, 1'b0, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_IAC,   1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_WILL,  1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{OPT_COMP2, 1'b1, 1'b0, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_IAC,   1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_SB,    1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{OPT_COMP2, 1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_IAC,   1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_SE,    1'b0, 1'b1, CH_EVENT, 8'h00,   EV_COMPRESS},
    '{CMD_IAC,   1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_SB,    1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_IAC,   1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE},
    '{CMD_SE,    1'b0, 1'b1, CH_NONE,  8'h00,   EV_NONE}
  };

  function automatic void emit(logic [1:0] ch, logic [7:0] b, logic [1:0] ev);
    out_item_t r;
    r = '0;
    r.channel = ch;
    r.out_byte = b;
    r.event_code = ev;
    pending.push_back(r);
  endfunction

  // 255 inside the size report goes out doubled
  function automatic void emit_size_byte(logic [7:0] b);
    if (b == 8'hFF) emit(CH_SOCKET, b, EV_NONE);
    emit(CH_SOCKET, b, EV_NONE);
  endfunction

  function automatic void send_window_size();
    int unsigned trim;
    logic [15:0] rows;
    trim = 1 + status_cfg;
    rows = (lines_cfg > trim) ? 16'(lines_cfg - trim) : 16'd0;
    emit(CH_SOCKET, CMD_IAC, EV_NONE);
    emit(CH_SOCKET, CMD_SB, EV_NONE);
    emit(CH_SOCKET, OPT_NAWS, EV_NONE);
    emit_size_byte(cols_cfg[15:8]);
    emit_size_byte(cols_cfg[7:0]);
    emit_size_byte(rows[15:8]);
    emit_size_byte(rows[7:0]);
    emit(CH_SOCKET, CMD_IAC, EV_NONE);
    emit(CH_SOCKET, CMD_SE, EV_NONE);
  endfunction

  function automatic logic [7:0] agree_reply(verb_t v);
    case (v)
      VB_WILL: return CMD_DO;
      VB_WONT: return CMD_DONT;
      default: return CMD_WONT;
    endcase
  endfunction

  function automatic void answer_option(verb_t v, logic [7:0] opt, logic window);
    logic [7:0] reply;
    reply = (v == VB_WILL || v == VB_WONT) ? CMD_DONT : CMD_WONT;
    if (opt == OPT_ECHO || opt == OPT_EOR || (opt == OPT_COMP2 && mccp_cfg)) begin
      reply = agree_reply(v);
      if (opt == OPT_ECHO) begin
        if (v == VB_WILL) echo_q = ECHO_SERVER;
        else if (v == VB_WONT) echo_q = ECHO_LOCAL;
      end else if (opt == OPT_COMP2) begin
        if (v == VB_WILL) compress_ok = window;
        else if (v == VB_WONT) compress_ok = 1'b0;
      end
    end else if (opt == OPT_TTYPE) begin
      if (v == VB_DO) reply = CMD_WILL;
    end else if (opt == OPT_NAWS) begin
      reply = agree_reply(v);
      if (v == VB_DO) begin
        reply = CMD_WILL;
        naws_q = (lines_cfg > 16'd1) && (cols_cfg != 16'd0);
      end else begin
        naws_q = 1'b0;
      end
    end
    emit(CH_SOCKET, CMD_IAC, EV_NONE);
    emit(CH_SOCKET, reply, EV_NONE);
    emit(CH_SOCKET, opt, EV_NONE);
    if (opt == OPT_NAWS) send_window_size();
  endfunction

  function automatic void sb_store(logic [7:0] b);
    if (sb_len > SUBNEG_LIMIT_DEF) begin
      // too long: drop everything and fall back to data
      emit(CH_EVENT, 8'd0, EV_SB_TOO_LONG);
      sb_len = 0;
      parse_q = PH_DATA;
    end else begin
      if (sb_len == 0) sb_option = b;
      else if (sb_len == 1) sb_second = b;
      sb_len++;
    end
  endfunction

  function automatic void sb_finish();
    if (sb_len >= 2 && sb_option == OPT_TTYPE && sb_second == TTYPE_SEND) begin
      emit(CH_EVENT, {6'd0, ttype_idx}, EV_TTYPE);
      // 0,1,2,3,3,0,...: last type index repeats once before wrapping
      if (ttype_idx != 2'd3) begin
        ttype_idx++;
      end else if (!ttype_wrap) begin
        ttype_wrap = 1'b1;
      end else begin
        ttype_wrap = 1'b0;
        ttype_idx = 2'd0;
      end
    end else if (sb_len >= 1 && sb_option == OPT_COMP2 && mccp_cfg && compress_ok) begin
      emit(CH_EVENT, 8'd0, EV_COMPRESS);
    end
    sb_len = 0;
    parse_q = PH_DATA;
  endfunction

  function automatic void predict_results(in_item_t it, script_row_t row);
    logic [7:0] b;
    logic [7:0] vdiff;
    out_item_t r;
    b = it.rx_byte;
    pending.delete();
    case (parse_q)
      PH_IAC: begin
        parse_q = PH_DATA;
        if (b >= CMD_WILL && b <= CMD_DONT) begin
          vdiff = b - CMD_WILL;
          verb_q = verb_t'(vdiff[1:0]);
          parse_q = PH_VERB;
        end else if (b == CMD_SB) begin
          sb_len = 0;
          parse_q = PH_SB;
        end else if (b == CMD_GA || b == CMD_EOR) begin
          ga_q = 1'b1;
          emit(CH_EVENT, 8'd0, EV_GO_AHEAD);
        end else if (b == CMD_IAC) begin
          emit(CH_USER, CMD_IAC, EV_NONE);
        end
      end
      PH_VERB: begin
        parse_q = PH_DATA;
        answer_option(verb_q, b, it.mccp_window);
      end
      PH_SB: begin
        if (b == CMD_IAC) parse_q = PH_SBIAC;
        else sb_store(b);
      end
      PH_SBIAC: begin
        if (b == CMD_SE) begin
          sb_finish();
        end else begin
          // a byte after IAC other than SE is kept as payload
          parse_q = PH_SB;
          sb_store(b);
        end
      end
      default: begin
        parse_q = PH_DATA;
        if (b == CMD_IAC) parse_q = PH_IAC;
        else emit(CH_USER, b, EV_NONE);
      end
    endcase
    if (pending.size() == 0) emit(CH_NONE, 8'd0, EV_NONE);

    if (row.typed) begin
      r = '0;
      r.channel = row.channel;
      r.out_byte = row.out_byte;
      r.event_code = row.event_code;
      r.last = 1'b1;
      r.echo_mode = echo_q;
      r.naws_on = naws_q;
      r.go_ahead_seen = ga_q;
      expected_results.push_back(r);
    end else begin
      for (int k = 0; k < pending.size(); k++) begin
        r = pending[k];
        r.last = (k == pending.size() - 1);
        r.echo_mode = echo_q;
        r.naws_on = naws_q;
        r.go_ahead_seen = ga_q;
        expected_results.push_back(r);
      end
    end
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(254));
    return b;
  endfunction

  // Builds one byte sequence of the given kind into burst
  function automatic void fill_burst(seq_kind_t kind);
    int n;
    logic [7:0] opt;
    burst.delete();
    case (kind)
      SEQ_DATA: begin
        n = $urandom_range(4, 1);
        repeat (n) burst.push_back(plain_byte());
      end
      SEQ_ESCAPE: begin
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_IAC);
      end
      SEQ_NEGOTIATE: begin
        case ($urandom_range(5))
          0: opt = OPT_ECHO;
          1: opt = OPT_TTYPE;
          2: opt = OPT_EOR;
          3: opt = OPT_NAWS;
          4: opt = OPT_COMP2;
          default: opt = 8'($urandom_range(255));
        endcase
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_WILL + 8'($urandom_range(3)));
        burst.push_back(opt);
      end
      SEQ_MARK: begin
        burst.push_back(CMD_IAC);
        burst.push_back($urandom_range(1) ? CMD_GA : CMD_EOR);
      end
      SEQ_SB_TTYPE: begin
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_SB);
        burst.push_back(OPT_TTYPE);
        case ($urandom_range(4))
          0: ;
          1: burst.push_back(plain_byte());
          default: burst.push_back(TTYPE_SEND);
        endcase
        repeat ($urandom_range(2)) burst.push_back(plain_byte());
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_SE);
      end
      SEQ_SB_COMPRESS: begin
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_SB);
        burst.push_back(OPT_COMP2);
        repeat ($urandom_range(2)) burst.push_back(plain_byte());
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_SE);
      end
      SEQ_SB_MIXED: begin
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_SB);
        repeat ($urandom_range(5)) begin
          case ($urandom_range(3))
            0: begin
              burst.push_back(CMD_IAC);
              burst.push_back(CMD_IAC);
            end
            1: begin
              burst.push_back(CMD_IAC);
              burst.push_back(8'($urandom_range(239)));
            end
            default: burst.push_back(plain_byte());
          endcase
        end
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_SE);
      end
      SEQ_SB_LONG: begin
        // first one always overruns; later ones straddle the limit
        n = overflow_done ? $urandom_range(SUBNEG_LIMIT_DEF + 4, SUBNEG_LIMIT_DEF - 1)
                          : SUBNEG_LIMIT_DEF + 2;
        if (n > SUBNEG_LIMIT_DEF + 1) overflow_done = 1'b1;
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_SB);
        repeat (n) burst.push_back(plain_byte());
        burst.push_back(CMD_IAC);
        burst.push_back(CMD_SE);
      end
      SEQ_OTHER_CMD: begin
        burst.push_back(CMD_IAC);
        burst.push_back(8'($urandom_range(248, 240)));
      end
      default: begin
        n = $urandom_range(3, 1);
        repeat (n) burst.push_back(8'($urandom_range(255)));
      end
    endcase
  endfunction

  task automatic push_byte(in_item_t it, script_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predict_results(it, row);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TERM_COLS:    cols_cfg = val;
      CFG_TERM_LINES:   lines_cfg = val;
      CFG_STATUS_LINE:  status_cfg = val[0];
      CFG_MCCP_ENABLED: mccp_cfg = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      if (fail_count < MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: result with none expected: expected nothing, got %h",
                   $time, out_item);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("channel", 8'(want.channel), 8'(out_item.channel));
        compare_field("out_byte", want.out_byte, out_item.out_byte);
        compare_field("event_code", 8'(want.event_code), 8'(out_item.event_code));
        compare_field("last", 8'(want.last), 8'(out_item.last));
        compare_field("echo_mode", 8'(want.echo_mode), 8'(out_item.echo_mode));
        compare_field("naws_on", 8'(want.naws_on), 8'(out_item.naws_on));
        compare_field("go_ahead_seen", 8'(want.go_ahead_seen),
                      8'(out_item.go_ahead_seen));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t it;
    seq_kind_t kind;
    bit kind_seen [N_KINDS];
    bit found;
    int roll;
    int phase_items;
    logic [15:0] cols_w, lines_w;
    logic status_w, mccp_w;

    parse_q = PH_DATA;
    verb_q = VB_WILL;
    sb_len = 0;
    sb_option = '0;
    sb_second = '0;
    echo_q = '0;
    naws_q = 1'b0;
    compress_ok = 1'b0;
    ga_q = 1'b0;
    ttype_idx = '0;
    ttype_wrap = 1'b0;
    cols_cfg = TERM_COLS_RST;
    lines_cfg = TERM_LINES_RST;
    status_cfg = STATUS_LINE_RST;
    mccp_cfg = MCCP_ENABLED_RST;
    foreach (kind_seen[k]) kind_seen[k] = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 26;
    stall_pct = 26;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      it.rx_byte = script_rows[i].rx;
      it.mccp_window = script_rows[i].window;
      push_byte(it, script_rows[i]);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      if (phase != 0) begin
        case (phase)
          1: begin cols_w = 16'd0;     lines_w = 16'd0;     status_w = 1'b1; mccp_w = 1'b0; end
          2: begin cols_w = 16'hFFFF;  lines_w = 16'hFFFF;  status_w = 1'b0; mccp_w = 1'b1; end
          4: begin cols_w = 16'd255;   lines_w = 16'd257;   status_w = 1'b1; mccp_w = 1'b1; end
          5: begin cols_w = 16'd1;     lines_w = 16'd1;     status_w = 1'b0; mccp_w = 1'b1; end
          default: begin
            cols_w = 16'($urandom_range(65535));
            lines_w = 16'($urandom_range(65535));
            status_w = 1'($urandom_range(1));
            mccp_w = 1'($urandom_range(1));
          end
        endcase
        write_reg(CFG_TERM_COLS, cols_w);
        write_reg(CFG_TERM_LINES, lines_w);
        write_reg(CFG_STATUS_LINE, {15'd0, status_w});
        write_reg(CFG_MCCP_ENABLED, {15'd0, mccp_w});
        cfg_valid <= 1'b0;
      end

      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase

      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        // every sequence kind once, then a weighted mix
        found = 1'b0;
        kind = SEQ_NOISE;
        for (int k = 0; k < N_KINDS; k++) begin
          if (!kind_seen[k] && !found) begin
            kind = seq_kind_t'(k);
            found = 1'b1;
          end
        end
        if (!found) begin
          roll = $urandom_range(99);
          if (roll < 10) kind = SEQ_DATA;
          else if (roll < 18) kind = SEQ_ESCAPE;
          else if (roll < 45) kind = SEQ_NEGOTIATE;
          else if (roll < 53) kind = SEQ_MARK;
          else if (roll < 65) kind = SEQ_SB_TTYPE;
          else if (roll < 73) kind = SEQ_SB_COMPRESS;
          else if (roll < 84) kind = SEQ_SB_MIXED;
          else if (roll < 86) kind = SEQ_SB_LONG;
          else if (roll < 93) kind = SEQ_OTHER_CMD;
          else kind = SEQ_NOISE;
        end
        kind_seen[kind] = 1'b1;
        fill_burst(kind);
        foreach (burst[i]) begin
          it.rx_byte = burst[i];
          it.mccp_window = 1'($urandom_range(1));
          push_byte(it, '0);
          phase_items++;
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/trn_pkg.sv
rtl/core/trn_parser.sv
rtl/core/trn_emitter.sv
rtl/core/telnet_receive_negotiator_core.sv
sim/testbench.sv
